// File: sv/assert_macros.svh
// Assertion macros shared by the IR pulse-distance decoder RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Invariant that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

`endif

// File: sv/irpd_pkg.sv
// Package of the IR pulse-distance decoder: widths, register indexes,
// reset values and the classified-item type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package irpd_pkg;

	localparam int US_W = 14;
	localparam int CODE_W = 32;
	localparam int PHASE_W = 3;
	localparam int REG_IDX_W = 3;
	localparam int CODE_BITS_DEFAULT = 32;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [US_W-1:0] us_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_HEADER_MIN   = 3'd0,
		REG_HEADER_MAX   = 3'd1,
		REG_MARK_MIN     = 3'd2,
		REG_MARK_MAX     = 3'd3,
		REG_SPACE_MIN    = 3'd4,
		REG_SPACE_MAX    = 3'd5,
		REG_ONE_THRESH   = 3'd6
	} reg_idx_t;

	localparam us_t HEADER_MIN_RST = 14'd4000;
	localparam us_t HEADER_MAX_RST = 14'd5000;
	localparam us_t MARK_MIN_RST   = 14'd400;
	localparam us_t MARK_MAX_RST   = 14'd700;
	localparam us_t SPACE_MIN_RST  = 14'd400;
	localparam us_t SPACE_MAX_RST  = 14'd1800;
	localparam us_t ONE_THRESH_RST = 14'd1000;

	// One input transaction after the window compares.
	typedef struct packed {
		logic timeout;
		logic hdr_ok;
		logic mark_ok;
		logic space_ok;
		logic is_one;
	} class_t;

endpackage

`default_nettype wire

// File: sv/irpd_ifs.sv
// Handshake interfaces of the IR pulse-distance decoder: input edges and
// decoded results. Depends on irpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface irpd_item_if;
	logic                   valid;
	logic                   ready;
	logic                   kind;
	logic [irpd_pkg::US_W-1:0] interval_us;

	modport source (output valid, output kind, output interval_us, input ready);
	modport sink (input valid, input kind, input interval_us, output ready);
endinterface

interface irpd_result_if;
	logic                        valid;
	logic                        ready;
	logic                        frame_done;
	logic [irpd_pkg::CODE_W-1:0]  code;
	logic                        frame_error;
	logic [irpd_pkg::PHASE_W-1:0] phase;

	modport source (output valid, output frame_done, output code, output frame_error,
		output phase, input ready);
	modport sink (input valid, input frame_done, input code, input frame_error,
		input phase, output ready);
endinterface

`default_nettype wire

// File: sv/ir_pulse_distance_decoder_unit.sv
// Top level of the IR pulse-distance decoder: front end, transaction queue
// and decode back end. Depends on irpd_pkg, irpd_ifs and the three submodules.
//
//   Channel   Direction  Payload
//   item      in         kind, interval_us
//   result    out        frame_done, code, frame_error, phase
//   wr_*      in         wr_index, wr_data (timing window registers)
//
// One transaction is taken per cycle while the queue has room; one result for each.
// The front end compares each interval with all windows in the cycle it is taken.
// A two-entry queue decouples the front end from the state machine in the back end.
// Input ready drops only while the queue is full behind a stalled result.
// Reset is asynchronous; window registers return to their default values.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_distance_decoder_unit #(
	parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	irpd_item_if.sink                          item,
	irpd_result_if.source                      result,
	input  wire logic                          wr_en,
	input  wire logic [irpd_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [irpd_pkg::US_W-1:0]      wr_data
);

	logic             queue_full;
	logic             push;
	irpd_pkg::class_t push_data;
	logic             pop;
	logic             head_valid;
	irpd_pkg::class_t head_data;

	irpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.item       (item),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	irpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	irpd_back #(
		.CODE_BITS (CODE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.result     (result)
	);

endmodule

`default_nettype wire

// File: sv/irpd_front.sv
// Front end: holds the timing window registers, accepts input transactions
// and classifies each interval against every window. Depends on irpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpd_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [irpd_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [irpd_pkg::US_W-1:0]      wr_data,
	irpd_item_if.sink                          item,
	input  wire logic                          queue_full,
	output logic                               push,
	output irpd_pkg::class_t                   push_data
);

	irpd_pkg::us_t header_min_q;
	irpd_pkg::us_t header_max_q;
	irpd_pkg::us_t mark_min_q;
	irpd_pkg::us_t mark_max_q;
	irpd_pkg::us_t space_min_q;
	irpd_pkg::us_t space_max_q;
	irpd_pkg::us_t one_thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_min_q <= irpd_pkg::HEADER_MIN_RST;
			header_max_q <= irpd_pkg::HEADER_MAX_RST;
			mark_min_q   <= irpd_pkg::MARK_MIN_RST;
			mark_max_q   <= irpd_pkg::MARK_MAX_RST;
			space_min_q  <= irpd_pkg::SPACE_MIN_RST;
			space_max_q  <= irpd_pkg::SPACE_MAX_RST;
			one_thresh_q <= irpd_pkg::ONE_THRESH_RST;
		end else if (wr_en) begin
			case (wr_index)
				irpd_pkg::REG_HEADER_MIN: header_min_q <= wr_data;
				irpd_pkg::REG_HEADER_MAX: header_max_q <= wr_data;
				irpd_pkg::REG_MARK_MIN:   mark_min_q   <= wr_data;
				irpd_pkg::REG_MARK_MAX:   mark_max_q   <= wr_data;
				irpd_pkg::REG_SPACE_MIN:  space_min_q  <= wr_data;
				irpd_pkg::REG_SPACE_MAX:  space_max_q  <= wr_data;
				irpd_pkg::REG_ONE_THRESH: one_thresh_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign item.ready = !queue_full;
	assign push = item.valid && !queue_full;

	always_comb begin
		push_data.timeout  = item.kind;
		push_data.hdr_ok   = (item.interval_us >= header_min_q) &&
			(item.interval_us <= header_max_q);
		push_data.mark_ok  = (item.interval_us >= mark_min_q) &&
			(item.interval_us <= mark_max_q);
		push_data.space_ok = (item.interval_us >= space_min_q) &&
			(item.interval_us <= space_max_q);
		push_data.is_one   = item.interval_us > one_thresh_q;
	end

endmodule

`default_nettype wire

// File: sv/irpd_queue.sv
// Short first-in first-out queue of classified transactions between the
// front end and the decode back end. Depends on irpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpd_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire irpd_pkg::class_t push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  head_valid,
	output irpd_pkg::class_t      head_data
);

	localparam int DEPTH = irpd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	irpd_pkg::class_t  entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/irpd_back.sv
// Decode back end: frame state machine, bit counter, code word and the
// registered result. Depends on irpd_pkg, irpd_ifs and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module irpd_back #(
	parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire irpd_pkg::class_t head_data,
	output logic                  pop,
	irpd_result_if.source         result
);

	localparam int CNT_W = $clog2(CODE_BITS + 1);
	localparam int IDX_W = $clog2(CODE_BITS);
	localparam int EXT_W = (CODE_BITS > irpd_pkg::CODE_W) ? CODE_BITS : irpd_pkg::CODE_W;

	typedef enum logic [irpd_pkg::PHASE_W-1:0] {
		PH_IDLE      = 3'd0,
		PH_HDR_MARK  = 3'd1,
		PH_HDR_SPACE = 3'd2,
		PH_BIT_MARK  = 3'd3,
		PH_BIT_SPACE = 3'd4
	} phase_t;

	phase_t                phase_q;
	phase_t                phase_d;
	logic [CNT_W-1:0]      bit_count_q;
	logic [CNT_W-1:0]      bit_count_d;
	logic [CODE_BITS-1:0]  shift_q;
	logic [CODE_BITS-1:0]  shift_d;
	logic                  valid_q;
	logic                  done_q;
	logic                  done_d;
	logic                  err_q;
	logic                  err_d;
	logic [IDX_W-1:0]      bit_pos;
	logic [EXT_W-1:0]      code_ext;

	assign pop     = head_valid && (!valid_q || result.ready);
	assign bit_pos = IDX_W'(CODE_BITS - 1) - bit_count_q[IDX_W-1:0];

	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		shift_d     = shift_q;
		done_d      = 1'b0;
		err_d       = 1'b0;
		if (head_data.timeout) begin
			phase_d = PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					bit_count_d = '0;
					phase_d     = PH_HDR_MARK;
				end
				PH_HDR_MARK: begin
					err_d   = !head_data.hdr_ok;
					phase_d = head_data.hdr_ok ? PH_HDR_SPACE : PH_IDLE;
				end
				PH_HDR_SPACE: begin
					err_d   = !head_data.hdr_ok;
					phase_d = head_data.hdr_ok ? PH_BIT_MARK : PH_IDLE;
				end
				PH_BIT_MARK: begin
					err_d   = !head_data.mark_ok;
					phase_d = head_data.mark_ok ? PH_BIT_SPACE : PH_IDLE;
				end
				PH_BIT_SPACE: begin
					if (!head_data.space_ok) begin
						err_d   = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_BIT_MARK;
						if (bit_count_q < CNT_W'(CODE_BITS)) begin
							shift_d[bit_pos] = head_data.is_one;
							bit_count_d      = bit_count_q + 1'b1;
							done_d           = bit_count_q == CNT_W'(CODE_BITS - 1);
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			shift_q     <= '0;
			valid_q     <= 1'b0;
			done_q      <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				bit_count_q <= bit_count_d;
				shift_q     <= shift_d;
				done_q      <= done_d;
				err_q       <= err_d;
				valid_q     <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign code_ext           = EXT_W'(shift_q);
	assign result.valid       = valid_q;
	assign result.frame_done  = done_q;
	assign result.frame_error = err_q;
	assign result.code        = code_ext[irpd_pkg::CODE_W-1:0];
	assign result.phase       = phase_q;

	`ASSERT_ALWAYS(a_count_range, clk, arst_n, bit_count_q <= CNT_W'(CODE_BITS), "bit count past code length")
	`ASSERT_IMPLIES(a_done_phase, clk, arst_n, valid_q && done_q, phase_q == PH_BIT_MARK && !err_q && bit_count_q == CNT_W'(CODE_BITS), "frame done without full code")
	`ASSERT_IMPLIES(a_err_idle, clk, arst_n, valid_q && err_q, phase_q == PH_IDLE, "error result not idle")
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, valid_q && !result.ready, valid_q && $stable(shift_q) && $stable(phase_q), "stalled result changed")

endmodule

`default_nettype wire
